/* rtl/tbg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbg_pkg: shared constants and table helper for the tone burst generator
// Field widths, register reset values, register index codes and the
// elaboration-time quarter-wave sine function.
// ----------------------------------------------------------------------------
package tbg_pkg;

  // default structural parameters
  localparam int DEF_INDEX_BITS     = 16;
  localparam int DEF_SINE_ADDR_BITS = 10;
  localparam int DEF_FADE_LEN       = 352;

  // field widths
  localparam int PHASE_W    = 32;
  localparam int STEP_W     = 31;
  localparam int TOTAL_W    = 16;
  localparam int VOL_W      = 15;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 15;
  localparam int Q15_W      = 16;
  localparam int FRAC_W     = 15;   // quotient bits of the envelope dividers
  localparam int DEC_W      = 19;   // holds 5 * burst length
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_SHIFT = 45;

  localparam logic [Q15_W-1:0] Q15_ONE = 16'h8000;

  // register reset values
  localparam logic [STEP_W-1:0]  RST_PHASE_STEP = 31'd97418273;
  localparam logic [TOTAL_W-1:0] RST_BURST_LEN  = 16'd4410;
  localparam logic [VOL_W-1:0]   RST_VOLUME     = 15'd13107;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 2'd2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin(k*pi/2 / 2^qbits) in Q0.15, from a Q30 Taylor series up to x^11;
  // only ever evaluated at elaboration
  function automatic logic [MAG_W-1:0] qsine(input int unsigned k,
                                             input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      s;
    longint      r;
    x  = (64'(k) * HALF_PI_Q30) >> qbits;
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - longint'(t);
    if (s < 0) begin
      s = 0;
    end
    r = (s + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return MAG_W'(r);
  endfunction

endpackage
`default_nettype wire

/* rtl/tone_burst_generator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tone_burst_generator_unit: sine tone burst with fade and decay envelope
// One input word per sample tick, one output word per tick.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one word per audio tick; in_start_req set (re)starts a burst at
//           sample zero and phase zero. A start is ignored while phase step,
//           length or volume is zero.
//   out_* : exactly one word per tick. Idle ticks give sample 0, active 0.
//           out_last marks the final sample of a burst.
//   cfg_* : register writes (0 phase step, 1 length, 2 volume); cfg_ready is
//           always high. Write only while no tick is in flight.
// Sequence
//   A burst sample goes through S_LOOK (table read, dividers and volume
//   multiply start), S_DIV (dividing), S_GD (gain times decay), S_FIN (final
//   multiply) and S_WB (writeback); an idle tick goes straight to S_WB.
//   One tick at a time, in_stall high meanwhile: a new tick is taken only
//   once the last one has been written back.
// Stalls
//   The output register holds a finished word while out_stall is high; the
//   next tick is still accepted, and its result waits in writeback.
// Reset
//   Synchronous, active low: idle, phase and index zero, registers back to
//   their defaults (phase step 97418273, length 4410, volume 13107).
// ----------------------------------------------------------------------------
module tone_burst_generator_unit
  import tbg_pkg::*;
#(
  parameter int INDEX_BITS     = DEF_INDEX_BITS,
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS,
  parameter int FADE_LEN       = DEF_FADE_LEN
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tick input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_start_req,
  // sample output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_active,
  output logic                       out_last,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FADE_W = $clog2(FADE_LEN + 1);
  localparam int CMP_W  = (INDEX_BITS > TOTAL_W) ? INDEX_BITS : TOTAL_W;
  localparam int M1_W   = MAG_W + VOL_W;          // |sine| * volume
  localparam int GD_W   = 2 * Q15_W - 1;          // gain * decay, <= 2^30
  localparam int M1P_W  = MAG_W + 2 * ((VOL_W + 1) / 2);
  localparam int GDP_W  = Q15_W + 2 * ((Q15_W + 1) / 2);
  localparam int FNP_W  = M1_W + 2 * ((GD_W + 1) / 2);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_DIV  = 6'b000100,
    S_GD   = 6'b001000,
    S_FIN  = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  // registers
  logic [STEP_W-1:0]     phase_step_r;
  logic [TOTAL_W-1:0]    burst_len_r;
  logic [VOL_W-1:0]      volume_r;

  // burst state
  state_t                state_r, state_nxt;
  logic                  busy_r, busy_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [PHASE_W-1:0]    phase_r, phase_nxt;

  // per-tick work registers
  logic [FADE_W-1:0]     fade_num_r, fade_den_r;
  logic                  g_full_r;
  logic [DEC_W-1:0]      dec_num_r, dec_den_r;
  logic                  last_r;
  logic                  neg_r;
  logic signed [SAMPLE_W-1:0] res_sample_r;
  logic                  res_active_r, res_last_r;

  // output register
  logic                  out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                  out_active_r, out_last_r;

  // tick decode
  logic                  in_fire;
  logic                  regs_ok, start_eff, busy_e, emit, fin;
  logic [INDEX_BITS-1:0] idx_e;
  logic [PHASE_W-1:0]    phase_e;
  logic [CMP_W-1:0]      idx_w, tot_w;
  logic [TOTAL_W-1:0]    i16, half, fade_len, fade_num16;
  logic                  g_full_c;

  // datapath
  logic [MAG_W-1:0]      sine_mag;
  logic                  sine_neg;
  logic                  fd_done, dd_done, m1_done, gd_done, fn_done;
  logic [FRAC_W-1:0]     fd_quot, dd_quot;
  logic [M1P_W-1:0]      m1_prod;
  logic [GDP_W-1:0]      gd_prod;
  logic [FNP_W-1:0]      fn_prod;
  logic [Q15_W-1:0]      gain, decay;
  logic [MAG_W-1:0]      res_mag;
  logic                  wb_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= RST_PHASE_STEP;
      burst_len_r  <= RST_BURST_LEN;
      volume_r     <= RST_VOLUME;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PHASE_STEP: phase_step_r <= cfg_wdata[STEP_W-1:0];
        CFG_BURST_LEN:  burst_len_r  <= cfg_wdata[TOTAL_W-1:0];
        CFG_VOLUME:     volume_r     <= cfg_wdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- tick decode: burst state moves on at acceptance -------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign regs_ok   = (phase_step_r != '0) && (burst_len_r != '0) && (volume_r != '0);
  assign start_eff = in_start_req && regs_ok;
  assign busy_e    = start_eff || busy_r;
  assign idx_e     = start_eff ? '0 : idx_r;
  assign phase_e   = start_eff ? '0 : phase_r;
  assign idx_w     = CMP_W'(idx_e);
  assign tot_w     = CMP_W'(burst_len_r);
  assign emit      = busy_e && regs_ok && (idx_w < tot_w);
  assign fin       = (idx_w == tot_w - 1'b1) || (idx_e == {INDEX_BITS{1'b1}});

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    if (busy_e && !emit) begin
      // register went to zero or length shrank to or below the index
      busy_nxt  = 1'b0;
      idx_nxt   = idx_e;
      phase_nxt = phase_e;
    end else if (emit) begin
      phase_nxt = phase_e + PHASE_W'(phase_step_r);
      busy_nxt  = !fin;
      idx_nxt   = fin ? '0 : idx_e + 1'b1;
    end
  end

  // envelope operands; the index is below the length here so 16 bits hold it
  assign i16  = TOTAL_W'(idx_e);
  assign half = burst_len_r >> 1;
  assign fade_len = (half < TOTAL_W'(FADE_LEN)) ? half : TOTAL_W'(FADE_LEN);

  always_comb begin
    g_full_c   = 1'b0;
    fade_num16 = '0;
    if (fade_len == '0) begin
      g_full_c = 1'b1;
    end else if (i16 < fade_len) begin
      fade_num16 = i16;
    end else if (i16 > burst_len_r - fade_len) begin
      fade_num16 = burst_len_r - i16;
    end else begin
      g_full_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      phase_r <= '0;
    end else if (in_fire) begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fade_num_r <= FADE_W'(fade_num16);
      fade_den_r <= FADE_W'(fade_len);
      g_full_r   <= g_full_c;
      dec_num_r  <= DEC_W'(i16);
      dec_den_r  <= (DEC_W'(burst_len_r) << 2) + DEC_W'(burst_len_r);
      last_r     <= fin;
    end
    if (state_r == S_LOOK) begin
      neg_r <= sine_neg;
    end
  end

  // ---- datapath ----------------------------------------------------------
  tbg_sine #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine (
    .clk   (clk),
    .phase (phase_e),
    .mag_r (sine_mag),
    .neg_r (sine_neg)
  );

  // fade gain: i/F or (total-i)/F
  tbg_sdiv #(
    .D_W (FADE_W),
    .Q_W (FRAC_W)
  ) u_fade_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_LOOK),
    .num    (fade_num_r),
    .den    (fade_den_r),
    .done_r (fd_done),
    .quot_r (fd_quot)
  );

  // decay: i / (5 * total)
  tbg_sdiv #(
    .D_W (DEC_W),
    .Q_W (FRAC_W)
  ) u_decay_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_LOOK),
    .num    (dec_num_r),
    .den    (dec_den_r),
    .done_r (dd_done),
    .quot_r (dd_quot)
  );

  // |sine| * volume runs alongside the dividers
  tbg_smul #(
    .A_W (MAG_W),
    .B_W (VOL_W)
  ) u_mul_vol (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_LOOK),
    .a      (sine_mag),
    .b      (volume_r),
    .done_r (m1_done),
    .prod_r (m1_prod)
  );

  assign gain  = g_full_r ? Q15_ONE : {1'b0, fd_quot};
  assign decay = Q15_ONE - {1'b0, dd_quot};

  tbg_smul #(
    .A_W (Q15_W),
    .B_W (Q15_W)
  ) u_mul_env (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_DIV && dd_done),
    .a      (decay),
    .b      (gain),
    .done_r (gd_done),
    .prod_r (gd_prod)
  );

  tbg_smul #(
    .A_W (M1_W),
    .B_W (GD_W)
  ) u_mul_fin (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_GD && gd_done),
    .a      (m1_prod[M1_W-1:0]),
    .b      (gd_prod[GD_W-1:0]),
    .done_r (fn_done),
    .prod_r (fn_prod)
  );

  // single truncation of the full product, sign applied last
  assign res_mag = fn_prod[PROD_SHIFT +: MAG_W];

  // ---- sequencer ---------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) begin
        state_nxt = emit ? S_LOOK : S_WB;
      end
      S_LOOK: state_nxt = S_DIV;
      S_DIV:  if (dd_done) begin
        state_nxt = S_GD;
      end
      S_GD:   if (gd_done) begin
        state_nxt = S_FIN;
      end
      S_FIN:  if (fn_done) begin
        state_nxt = S_WB;
      end
      S_WB:   if (wb_fire) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !emit) begin
      res_sample_r <= '0;
      res_active_r <= 1'b0;
      res_last_r   <= 1'b0;
    end else if (state_r == S_FIN && fn_done) begin
      res_sample_r <= neg_r ? -$signed(SAMPLE_W'(res_mag)) : $signed(SAMPLE_W'(res_mag));
      res_active_r <= 1'b1;
      res_last_r   <= last_r;
    end
  end

  // ---- output register ---------------------------------------------------
  assign wb_fire = (state_r == S_WB) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_sample_r <= res_sample_r;
      out_active_r <= res_active_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_active     = out_active_r;
  assign out_last       = out_last_r;

  // ---- checks ------------------------------------------------------------
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    fd_done == dd_done)
    else $error("envelope dividers out of step");

  a_mul_before_env: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GD && gd_done) |-> !m1_done)
    else $error("volume product not ready for final multiply");

  a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_active)
    else $error("last flagged on an idle word");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_active) |-> (out_sample_out == '0))
    else $error("idle word carries a sample");

  a_no_neg_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_out != 16'sh8000))
    else $error("sample magnitude overflow");

endmodule
`default_nettype wire

/* rtl/tbg_sine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbg_sine: quarter-wave sine lookup
// Folds the phase into one quadrant, reads the constant table and registers
// the magnitude and the sign.
// ----------------------------------------------------------------------------
module tbg_sine
  import tbg_pkg::*;
#(
  parameter int SINE_ADDR_BITS = DEF_SINE_ADDR_BITS
) (
  input  wire logic               clk,
  input  wire logic [PHASE_W-1:0] phase,
  output logic      [MAG_W-1:0]   mag_r,
  output logic                    neg_r
);

  localparam int QBITS = SINE_ADDR_BITS - 2;
  localparam int QLEN  = 1 << QBITS;
  localparam int TI_W  = QBITS + 1;

  logic [MAG_W-1:0]          tab [QLEN+1];
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QBITS-1:0]          qpos;
  logic [TI_W-1:0]           tab_idx;

  for (genvar k = 0; k <= QLEN; k++) begin : g_tab
    localparam logic [MAG_W-1:0] ENTRY = qsine(k, QBITS);
    assign tab[k] = ENTRY;
  end

  assign addr = phase[PHASE_W-1 -: SINE_ADDR_BITS];
  assign quad = addr[SINE_ADDR_BITS-1 -: 2];
  assign qpos = addr[QBITS-1:0];

  // odd quadrants run the table backwards
  always_comb begin
    if (quad[0]) begin
      tab_idx = TI_W'(QLEN) - {1'b0, qpos};
    end else begin
      tab_idx = {1'b0, qpos};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= tab[tab_idx];
    neg_r <= quad[1];
  end

endmodule
`default_nettype wire

/* rtl/tbg_sdiv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbg_sdiv: bit-serial fractional divider
// floor(num * 2^Q_W / den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbg_sdiv
  import tbg_pkg::*;
#(
  parameter int D_W = 16,
  parameter int Q_W = FRAC_W
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [D_W-1:0] num,
  input  wire logic [D_W-1:0] den,
  output logic                done_r,
  output logic      [Q_W-1:0] quot_r
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [D_W-1:0]   den_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W:0]     rem_sh;
  logic             ge;
  logic [D_W-1:0]   rem_nxt;

  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    if (ge) begin
      rem_nxt = D_W'(rem_sh - {1'b0, den_r});
    end else begin
      rem_nxt = D_W'(rem_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(Q_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[Q_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* rtl/tbg_smul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbg_smul: radix-4 serial multiplier
// Unsigned a * b, two multiplier bits per cycle, shift-add on a narrow adder.
// ----------------------------------------------------------------------------
module tbg_smul #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [A_W-1:0] a,
  input  wire logic [B_W-1:0] b,
  output logic                done_r,
  output logic [A_W+2*((B_W+1)/2)-1:0] prod_r
);

  localparam int STEPS = (B_W + 1) / 2;
  localparam int BP_W  = 2 * STEPS;
  localparam int P_W   = A_W + BP_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [A_W+1:0]   a1_r;
  logic [A_W+1:0]   a2_r;
  logic [A_W+1:0]   a3_r;
  logic [A_W+1:0]   addend;
  logic [A_W+1:0]   sum;
  logic [P_W-1:0]   prod_nxt;

  always_comb begin
    case (prod_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = a1_r;
      2'd2:    addend = a2_r;
      2'd3:    addend = a3_r;
      default: addend = '0;
    endcase
  end

  assign sum      = (A_W+2)'(prod_r[P_W-1:BP_W]) + addend;
  assign prod_nxt = {sum, prod_r[BP_W-1:2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CNT_W'(STEPS);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a1_r   <= (A_W+2)'(a);
      a2_r   <= (A_W+2)'({a, 1'b0});
      a3_r   <= (A_W+2)'(a) + (A_W+2)'({a, 1'b0});
      prod_r <= {{A_W{1'b0}}, BP_W'(b)};
    end else if (cnt_r != '0) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire
